[rtl/afrl_pkg.sv]
// Shared types and constants for the antenna failover controller.
// Used by every module of the block and by its checker.
package afrl_pkg;

    // Result state codes, as they appear on the result beat
    localparam logic [1:0] STATE_IDLE      = 2'd0;
    localparam logic [1:0] STATE_WAITING   = 2'd1;
    localparam logic [1:0] STATE_SWITCHING = 2'd2;
    localparam logic [1:0] STATE_COOLDOWN  = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;

    // Opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_FORCE  = 1'b1;

    // Register indexes
    localparam logic [0:0] REG_TIMEOUT  = 1'd0;
    localparam logic [0:0] REG_INIT_ANT = 1'd1;

    // Time constants
    localparam int unsigned MS_PER_S        = 1000;
    localparam int unsigned S_PER_MIN       = 60;
    localparam int unsigned SEC_PER_HOUR    = 60 * 60;
    localparam int unsigned ONE_HOUR_MS     = SEC_PER_HOUR * MS_PER_S;
    localparam int unsigned MS_PER_MIN      = S_PER_MIN * MS_PER_S;
    localparam int unsigned MAX_TIMEOUT_MIN = 60;

    // floor(x / 1000) for 32-bit x: (x * ceil(2^38 / 1000)) >> 38
    localparam int unsigned DIV_SHIFT = 38;
    localparam int unsigned DIV_MULT  = 274877907;
    localparam int unsigned DIV_MW    = 29;
    localparam int unsigned DIV_PW    = 32 + DIV_MW;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now_ms;
        logic        has_fix;
        logic        switch_ok;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] hist_count;
        logic       switch_pulse;
        logic       antenna_select;
        logic [1:0] fsm_state;
    } res_beat_t;

    typedef struct packed {
        logic       en;
        logic [0:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0] timeout_minutes;
        logic       initial_antenna;
    } cfg_rd_t;

endpackage

[rtl/afrl_sec_div.sv]
// Millisecond to second conversion by reciprocal multiplication.
// Depends on afrl_pkg for the reciprocal constants.
module afrl_sec_div
    import afrl_pkg::*;
(
    input  logic [31:0] now_ms,
    output logic [31:0] now_s
);

    logic [DIV_PW-1:0] prod;

    assign prod  = DIV_PW'(now_ms) * DIV_PW'(DIV_MULT);
    assign now_s = 32'(prod[DIV_PW-1:DIV_SHIFT]);

endmodule

[rtl/afrl_fsm.sv]
// Failover state machine, switch history and configuration registers.
// Depends on afrl_pkg; the result for a beat is formed combinationally.
module afrl_fsm
    import afrl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  item_t       item,
    input  logic [31:0] now_s,
    input  cfg_wr_t     cfg,
    output cfg_rd_t     cfg_rd,
    output res_beat_t   res
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        M_IDLE      = STATE_IDLE,
        M_WAITING   = STATE_WAITING,
        M_SWITCHING = STATE_SWITCHING,
        M_COOLDOWN  = STATE_COOLDOWN
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [31:0]  entry_reg, entry_next;
    logic [31:0]  stamps_reg [HISTORY_DEPTH];
    logic [31:0]  stamps_next [HISTORY_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic         ant_reg, ant_next;
    logic [7:0]   timeout_reg;
    logic [31:0]  timeout_ms_reg;
    logic         init_ant_reg;

    logic [31:0]  elapsed;
    logic [31:0]  since_oldest;
    logic         limit;
    logic         pulse;
    logic [1:0]   status;
    logic [5:0]   tmin;

    assign elapsed      = item.now_ms - entry_reg;
    assign since_oldest = now_s - stamps_reg[HISTORY_DEPTH-1];
    assign limit        = (count_reg >= DEPTH_C) && (since_oldest < SEC_PER_HOUR);
    assign tmin = (cfg.data > 8'(MAX_TIMEOUT_MIN)) ? 6'(MAX_TIMEOUT_MIN) : cfg.data[5:0];

    always_comb begin
        mode_next  = mode_reg;
        entry_next = entry_reg;
        count_next = count_reg;
        ant_next   = ant_reg;
        pulse      = 1'b0;
        status     = STATUS_OK;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            stamps_next[i] = stamps_reg[i];
        end
        if (item.opcode == OP_FORCE) begin
            if (mode_reg == M_SWITCHING) begin
                status = STATUS_BUSY;
            end else if (item.switch_ok) begin
                ant_next   = ~ant_reg;
                pulse      = 1'b1;
                mode_next  = M_IDLE;
                entry_next = item.now_ms;
            end else begin
                status = STATUS_FAIL;
            end
        end else begin
            case (mode_reg)
                M_IDLE: begin
                    if (!item.has_fix && timeout_ms_reg != 32'd0) begin
                        mode_next  = M_WAITING;
                        entry_next = item.now_ms;
                    end
                end
                M_WAITING: begin
                    if (item.has_fix) begin
                        mode_next  = M_IDLE;
                        entry_next = item.now_ms;
                    end else if (elapsed >= timeout_ms_reg) begin
                        mode_next  = limit ? M_COOLDOWN : M_SWITCHING;
                        entry_next = item.now_ms;
                    end
                end
                M_SWITCHING: begin
                    if (item.switch_ok) begin
                        ant_next = ~ant_reg;
                        pulse    = 1'b1;
                        // shift history, newest stamp at the front
                        for (int i = 1; i < HISTORY_DEPTH; i++) begin
                            stamps_next[i] = stamps_reg[i-1];
                        end
                        stamps_next[0] = now_s;
                        if (count_reg < DEPTH_C) begin
                            count_next = count_reg + CW'(1);
                        end
                    end else begin
                        status = STATUS_FAIL;
                    end
                    mode_next  = M_IDLE;
                    entry_next = item.now_ms;
                end
                M_COOLDOWN: begin
                    if (elapsed >= ONE_HOUR_MS) begin
                        for (int i = 0; i < HISTORY_DEPTH; i++) begin
                            stamps_next[i] = 32'd0;
                        end
                        count_next = '0;
                        mode_next  = M_IDLE;
                        entry_next = item.now_ms;
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            entry_reg      <= 32'd0;
            count_reg      <= '0;
            ant_reg        <= 1'b0;
            timeout_reg    <= 8'd0;
            timeout_ms_reg <= 32'd0;
            init_ant_reg   <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                stamps_reg[i] <= 32'd0;
            end
        end else begin
            if (step) begin
                mode_reg  <= mode_next;
                entry_reg <= entry_next;
                count_reg <= count_next;
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    stamps_reg[i] <= stamps_next[i];
                end
            end
            // a preset write loads the antenna at once
            if (cfg.en && cfg.index == REG_INIT_ANT) begin
                ant_reg <= cfg.data[0];
            end else if (step) begin
                ant_reg <= ant_next;
            end
            if (cfg.en) begin
                case (cfg.index)
                    REG_TIMEOUT: begin
                        timeout_reg    <= cfg.data;
                        timeout_ms_reg <= 32'(tmin) * MS_PER_MIN;
                    end
                    REG_INIT_ANT: begin
                        init_ant_reg <= cfg.data[0];
                    end
                    default: begin
                        timeout_reg <= timeout_reg;
                    end
                endcase
            end
        end
    end

    assign cfg_rd.timeout_minutes = timeout_reg;
    assign cfg_rd.initial_antenna = init_ant_reg;

    assign res.fsm_state      = mode_next;
    assign res.antenna_select = ant_next;
    assign res.switch_pulse   = pulse;
    assign res.hist_count     = (32'(count_next) > 32'd7) ? 3'd7 : 3'(count_next);
    assign res.status         = status;

endmodule

[rtl/antenna_failover_rate_limited_top.sv]
// Antenna failover controller with a rate limit on automatic switches.
// Instantiates afrl_sec_div and afrl_fsm; depends on afrl_pkg.
//
// Usage:
//   s_ beats carry one event each: tuser[0] is the opcode (update or forced
//   switch), tdata holds the millisecond time, the fix flag and the
//   switch-success flag. Every accepted beat yields exactly one m_ beat with
//   the state, antenna, switch pulse, history count and status after it.
//   Configuration goes through the APB port: timeout in minutes at 0x0,
//   initial antenna at 0x4 (writing it loads the antenna at once).
// Stages and rate:
//   Three stages: input register, seconds conversion register, result
//   register. One beat per cycle is sustained while m_tready stays high;
//   the state update is a loop closed within the state machine stage, so
//   nothing waits on an earlier beat.
// Reset and stalls:
//   Synchronous active-low reset empties the pipeline, clears the history,
//   returns to idle and zeroes both registers. When m_tready is low the
//   result holds and the stages behind it fill, then s_tready drops.
module antenna_failover_rate_limited_top
    import afrl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] now_ms, [32] has_fix, [33] switch_ok, zero pad
    input  logic [0:0]  s_tuser,   // [0] opcode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] fsm_state, [2] antenna_select, [3] switch_pulse,
                                   // [6:4] hist_count, [8:7] status, zero pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        a_valid_reg, b_valid_reg, m_valid_reg;
    item_t       a_item_reg, b_item_reg;
    logic [31:0] b_now_s_reg;
    res_beat_t   m_res_reg;

    logic        out_free, b_adv, b_free, a_adv, s_acc;
    item_t       s_item;
    logic [31:0] a_now_s;
    res_beat_t   res;
    cfg_wr_t     cfg;
    cfg_rd_t     cfg_rd;

    assign out_free = !m_valid_reg || m_tready;
    assign b_adv    = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || b_adv;
    assign a_adv    = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || a_adv;
    assign s_acc    = s_tvalid && s_tready;

    assign s_item.opcode    = s_tuser[0];
    assign s_item.now_ms    = s_tdata[31:0];
    assign s_item.has_fix   = s_tdata[32];
    assign s_item.switch_ok = s_tdata[33];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_item_reg <= s_item;
        end
        if (a_adv) begin
            b_item_reg  <= a_item_reg;
            b_now_s_reg <= a_now_s;
        end
        if (b_adv) begin
            m_res_reg <= res;
        end
    end

    afrl_sec_div u_sec_div (
        .now_ms (a_item_reg.now_ms),
        .now_s  (a_now_s)
    );

    assign cfg.en    = psel && penable && pwrite;
    assign cfg.index = paddr[2:2];
    assign cfg.data  = pwdata[7:0];

    afrl_fsm #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (b_adv),
        .item    (b_item_reg),
        .now_s   (b_now_s_reg),
        .cfg     (cfg),
        .cfg_rd  (cfg_rd),
        .res     (res)
    );

    always_comb begin
        case (paddr[2:2])
            REG_TIMEOUT:  prdata = {24'd0, cfg_rd.timeout_minutes};
            REG_INIT_ANT: prdata = {31'd0, cfg_rd.initial_antenna};
            default:      prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg};

endmodule

[rtl/afrl_checker.sv]
// Port-level checks for the antenna failover controller, bound to its top.
// Depends on afrl_pkg for state and status codes.
module afrl_checker
    import afrl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [1:0] st;
    logic       pulse;
    logic [1:0] status;

    assign st     = m_tdata[1:0];
    assign pulse  = m_tdata[3];
    assign status = m_tdata[8:7];

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a toggle always lands in idle with ok status
    a_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && pulse |-> st == STATE_IDLE && status == STATUS_OK)
        else $error("switch pulse outside idle or with error status");

    // a refused force leaves the block in switching
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == STATUS_BUSY |-> st == STATE_SWITCHING && !pulse)
        else $error("busy status outside switching");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind antenna_failover_rate_limited_top afrl_checker u_afrl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
